// ===== rtl/pfcb_pkg.sv =====
// Shared types and constants for the per-file credit bucket block.
package pfcb_pkg;

	localparam int SLOTS     = 16;
	localparam int TIME_BITS = 32;

	localparam int ACT_W   = 2;
	localparam int SLOT_W  = 4;
	localparam int NOW_W   = 32;
	localparam int CRED_W  = 10;
	localparam int CNT_W   = 8;
	localparam int FLASH_W = 2;
	localparam int CFG_IW  = 3;
	localparam int CFG_DW  = 10;

	// stored time width: the input field is masked to TIME_BITS
	localparam int TW      = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
	localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PROD_W  = 2 * CRED_W;

	localparam logic [ACT_W-1:0] ACT_REFILL = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CHARGE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FLASH  = 2'd2;

	localparam logic [CFG_IW-1:0] REG_MAX_CREDITS     = 3'd0;
	localparam logic [CFG_IW-1:0] REG_REFILL_RATE     = 3'd1;
	localparam logic [CFG_IW-1:0] REG_CHARGE_AMOUNT   = 3'd2;
	localparam logic [CFG_IW-1:0] REG_FLASH_AMOUNT    = 3'd3;
	localparam logic [CFG_IW-1:0] REG_FLASH_ALLOWANCE = 3'd4;
	localparam logic [CFG_IW-1:0] REG_WARN_LEVEL      = 3'd5;

	typedef struct packed {
		logic [CRED_W-1:0]  max_credits;
		logic [CRED_W-1:0]  refill_rate;
		logic [CRED_W-1:0]  charge_amount;
		logic [CRED_W-1:0]  flash_amount;
		logic [FLASH_W-1:0] flash_allowance;
		logic [CRED_W-1:0]  warn_level;
	} cfg_t;

	typedef struct packed {
		logic               live;
		logic [CRED_W-1:0]  credits;
		logic [TW-1:0]      last_time;
		logic [CNT_W-1:0]   warns;
		logic [FLASH_W-1:0] flash;
	} entry_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [SLOT_W-1:0] slot;
		logic [TW-1:0]     now;
	} item_t;

	typedef struct packed {
		logic [CRED_W-1:0]  credits_left;
		logic               exhausted;
		logic               repeat_exhaust;
		logic               low_warning;
		logic [CNT_W-1:0]   warn_count;
		logic [FLASH_W-1:0] flash_left;
		logic               flash_applied;
		logic               not_ready;
	} result_t;

	// table write request from the update logic
	typedef struct packed {
		logic               we;
		logic [SLOT_IW-1:0] idx;
		entry_t             data;
	} tbl_wr_t;

endpackage

// ===== rtl/pfcb_cfg.sv =====
// Configuration registers of the credit bucket block.
module pfcb_cfg import pfcb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_credits     <= CRED_W'(600);
			cfg_q.refill_rate     <= CRED_W'(1);
			cfg_q.charge_amount   <= CRED_W'(40);
			cfg_q.flash_amount    <= CRED_W'(20);
			cfg_q.flash_allowance <= FLASH_W'(2);
			cfg_q.warn_level      <= CRED_W'(40);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_CREDITS:     cfg_q.max_credits     <= cfg_data[CRED_W-1:0];
				REG_REFILL_RATE:     cfg_q.refill_rate     <= cfg_data[CRED_W-1:0];
				REG_CHARGE_AMOUNT:   cfg_q.charge_amount   <= cfg_data[CRED_W-1:0];
				REG_FLASH_AMOUNT:    cfg_q.flash_amount    <= cfg_data[CRED_W-1:0];
				REG_FLASH_ALLOWANCE: cfg_q.flash_allowance <= cfg_data[FLASH_W-1:0];
				REG_WARN_LEVEL:      cfg_q.warn_level      <= cfg_data[CRED_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/pfcb_table.sv =====
// Per-slot bucket state table: live bits with reset, payload without.
module pfcb_table import pfcb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [SLOT_IW-1:0] rd_idx,
	output entry_t             rd_entry,
	input  tbl_wr_t            wr
);

	logic [SLOTS-1:0] live_q;
	entry_t           ent_q [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (wr.we) begin
			live_q[wr.idx] <= wr.data.live;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we) begin
			ent_q[wr.idx] <= wr.data;
		end
	end

	// a slot never refilled reads as all zero
	always_comb begin
		if (live_q[rd_idx]) begin
			rd_entry      = ent_q[rd_idx];
			rd_entry.live = 1'b1;
		end else begin
			rd_entry = '0;
		end
	end

endmodule

// ===== rtl/pfcb_calc.sv =====
// Bucket update logic: next slot state and result for one item.
module pfcb_calc import pfcb_pkg::*; (
	input  cfg_t    cfg,
	input  item_t   item,
	input  entry_t  cur,
	output entry_t  nxt,
	output logic    upd,
	output result_t res
);

	logic              in_range;
	logic              later;
	logic [TW-1:0]     diff;
	logic              far;
	logic              add_ok;
	logic [PROD_W-1:0] prod;
	logic [PROD_W:0]   sum;
	logic [CRED_W-1:0] after_charge;

	assign in_range = int'(item.slot) < SLOTS;
	assign later    = item.now > cur.last_time;
	assign diff     = item.now - cur.last_time;
	assign far      = |diff[TW-1:CRED_W];
	assign add_ok   = later && (cfg.refill_rate != '0);
	assign prod     = diff[CRED_W-1:0] * cfg.refill_rate;
	assign sum      = (add_ok && !far) ? ((PROD_W+1)'(cur.credits) + (PROD_W+1)'(prod))
	                                   : (PROD_W+1)'(cur.credits);
	assign after_charge = cur.credits - cfg.charge_amount;

	always_comb begin
		nxt = cur;
		upd = 1'b0;
		res = '0;
		if (in_range) begin
			case (item.action)
				ACT_REFILL: begin
					upd = 1'b1;
					if (!cur.live) begin
						nxt.live    = 1'b1;
						nxt.credits = cfg.max_credits;
						nxt.warns   = '0;
						nxt.flash   = cfg.flash_allowance;
					end else if ((add_ok && far) || sum > (PROD_W+1)'(cfg.max_credits)) begin
						nxt.credits = cfg.max_credits;
					end else begin
						nxt.credits = sum[CRED_W-1:0];
					end
					nxt.last_time = item.now;
				end
				ACT_CHARGE: begin
					if (!cur.live) begin
						res.not_ready = 1'b1;
					end else begin
						upd = 1'b1;
						if (cur.credits <= cfg.charge_amount) begin
							nxt.credits        = '0;
							res.exhausted      = 1'b1;
							res.repeat_exhaust = cur.warns != '0;
						end else begin
							nxt.credits = after_charge;
							if (after_charge <= cfg.warn_level) begin
								res.low_warning = 1'b1;
								if (cur.warns != '1) begin
									nxt.warns = cur.warns + CNT_W'(1);
								end
							end
						end
					end
				end
				ACT_FLASH: begin
					if (!cur.live) begin
						res.not_ready = 1'b1;
					end else if (cur.flash != '0) begin
						upd               = 1'b1;
						nxt.flash         = cur.flash - FLASH_W'(1);
						nxt.credits       = (cur.credits > cfg.flash_amount)
						                  ? cur.credits - cfg.flash_amount : '0;
						res.flash_applied = 1'b1;
					end
				end
				default: ;
			endcase
			res.credits_left = nxt.credits;
			res.warn_count   = nxt.warns;
			res.flash_left   = nxt.flash;
		end else begin
			res.not_ready = 1'b1;
		end
	end

endmodule

// ===== rtl/per_file_credit_bucket.sv =====
// Top level of the per-file credit bucket (token bucket rate limiter).
//
// One bucket per watched file slot, credits in fortieths. Input beats carry
// action (refill, charge, flash), slot and now_seconds; each beat yields one
// result beat with the slot's level, warning count, flash allowance and flags.
// Both channels use valid/stall: a beat moves on a rising edge with valid high
// and stall low. Config registers are written through cfg_we/cfg_index/
// cfg_data; the user must write them while the block is idle, it is not enforced.
//
// A beat goes from the input register to the result register. Throughput:
// one beat per cycle while out_stall is low. The input register feeds one
// pass of update logic (one 10x10 multiply, time subtract and clamp) that
// writes the slot table and the result register at the same edge, so beats
// back to back on the same slot see each other's updates with no forwarding.
// When the receiver stalls, the result register holds; the input register
// still fills once, and in_stall rises only while both are occupied.
// Reset clears the live bits of all slots (every slot reads as zero until its
// first refill), drops both registers and loads the config reset values.
module per_file_credit_bucket import pfcb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_IW-1:0]  cfg_index,
	input  logic [CFG_DW-1:0]  cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ACT_W-1:0]   action,
	input  logic [SLOT_W-1:0]  slot,
	input  logic [NOW_W-1:0]   now_seconds,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CRED_W-1:0]  credits_left,
	output logic               exhausted,
	output logic               repeat_exhaust,
	output logic               low_warning,
	output logic [CNT_W-1:0]   warn_count,
	output logic [FLASH_W-1:0] flash_left,
	output logic               flash_applied,
	output logic               not_ready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    res_valid_q;

	entry_t  cur;
	entry_t  nxt;
	logic    upd;
	result_t res;
	tbl_wr_t wr;
	logic    advance;
	logic    take;

	pfcb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// beat in the input register moves on when the result slot frees up
	assign advance  = valid_s1 && (!res_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.action <= action;
			item_s1.slot   <= slot;
			item_s1.now    <= TW'(now_seconds);
		end
	end

	pfcb_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (SLOT_IW'(item_s1.slot)),
		.rd_entry (cur),
		.wr       (wr)
	);

	pfcb_calc u_calc (
		.cfg  (cfg),
		.item (item_s1),
		.cur  (cur),
		.nxt  (nxt),
		.upd  (upd),
		.res  (res)
	);

	// state commits only on the edge the result is captured
	assign wr.we   = advance && upd;
	assign wr.idx  = SLOT_IW'(item_s1.slot);
	assign wr.data = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid      = res_valid_q;
	assign credits_left   = res_q.credits_left;
	assign exhausted      = res_q.exhausted;
	assign repeat_exhaust = res_q.repeat_exhaust;
	assign low_warning    = res_q.low_warning;
	assign warn_count     = res_q.warn_count;
	assign flash_left     = res_q.flash_left;
	assign flash_applied  = res_q.flash_applied;
	assign not_ready      = res_q.not_ready;

endmodule

// ===== dv/per_file_credit_bucket_tb.sv =====
// Self-checking testbench for the per-file credit bucket block.
module per_file_credit_bucket_tb;
	import pfcb_pkg::*;

	// action code 3 is unused by the block, but the field can carry it
	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

	localparam int DRAIN_LIMIT = 20000; // cycles to wait for a phase to empty
	localparam int HOLD_AT     = 120;   // results seen before the long hold-off
	localparam int HOLD_CYCLES = 80;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CFG_IW-1:0]  cfg_index = '0;
	logic [CFG_DW-1:0]  cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [ACT_W-1:0]   action = ACT_REFILL;
	logic [SLOT_W-1:0]  slot = '0;
	logic [NOW_W-1:0]   now_seconds = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [CRED_W-1:0]  credits_left;
	logic               exhausted;
	logic               repeat_exhaust;
	logic               low_warning;
	logic [CNT_W-1:0]   warn_count;
	logic [FLASH_W-1:0] flash_left;
	logic               flash_applied;
	logic               not_ready;

	per_file_credit_bucket i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.slot           (slot),
		.now_seconds    (now_seconds),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.credits_left   (credits_left),
		.exhausted      (exhausted),
		.repeat_exhaust (repeat_exhaust),
		.low_warning    (low_warning),
		.warn_count     (warn_count),
		.flash_left     (flash_left),
		.flash_applied  (flash_applied),
		.not_ready      (not_ready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Bucket predictor: config shadow plus per-slot table, updated per beat
	// ------------------------------------------------------------------
	logic [CRED_W-1:0]  cfg_max    = 10'd600;
	logic [CRED_W-1:0]  cfg_rate   = 10'd1;
	logic [CRED_W-1:0]  cfg_charge = 10'd40;
	logic [CRED_W-1:0]  cfg_flash  = 10'd20;
	logic [FLASH_W-1:0] cfg_allow  = 2'd2;
	logic [CRED_W-1:0]  cfg_warn   = 10'd40;

	logic [CRED_W-1:0]  bkt_credits [SLOTS];
	logic [TW-1:0]      bkt_last    [SLOTS];
	logic [CNT_W-1:0]   bkt_warns   [SLOTS];
	logic [FLASH_W-1:0] bkt_flash   [SLOTS];
	logic               bkt_live    [SLOTS];

	function automatic result_t bucket_step(item_t it);
		result_t    r;
		int         s;
		logic [31:0] c;
		logic [31:0] el;
		r = '0;
		if (int'(it.slot) >= SLOTS) begin
			r.not_ready = 1'b1;
			return r;
		end
		s = int'(it.slot);
		case (it.action)
			ACT_REFILL: begin
				if (!bkt_live[s]) begin
					// first touch: full bucket, fresh flash allowance
					bkt_credits[s] = cfg_max;
					bkt_warns[s]   = '0;
					bkt_flash[s]   = cfg_allow;
					bkt_live[s]    = 1'b1;
				end else begin
					c = 32'(bkt_credits[s]);
					// an earlier time adds nothing, but the clamp still applies
					if (it.now > bkt_last[s] && cfg_rate != '0) begin
						el = 32'(it.now - bkt_last[s]);
						if (el > 32'd1023)
							c = 32'(cfg_max);
						else
							c = c + el * 32'(cfg_rate);
					end
					if (c > 32'(cfg_max))
						c = 32'(cfg_max);
					bkt_credits[s] = c[CRED_W-1:0];
				end
				bkt_last[s] = it.now;
			end
			ACT_CHARGE, ACT_FLASH: begin
				if (!bkt_live[s]) begin
					r.not_ready = 1'b1;
					return r;
				end
				if (it.action == ACT_CHARGE) begin
					if (bkt_credits[s] <= cfg_charge) begin
						bkt_credits[s]   = '0;
						r.exhausted      = 1'b1;
						r.repeat_exhaust = (bkt_warns[s] != '0);
					end else begin
						bkt_credits[s] = bkt_credits[s] - cfg_charge;
						if (bkt_credits[s] <= cfg_warn) begin
							r.low_warning = 1'b1;
							if (bkt_warns[s] != '1)
								bkt_warns[s] = bkt_warns[s] + 1'b1;
						end
					end
				end else if (bkt_flash[s] != '0) begin
					bkt_flash[s]   = bkt_flash[s] - 1'b1;
					bkt_credits[s] = (bkt_credits[s] > cfg_flash) ?
						bkt_credits[s] - cfg_flash : '0;
					r.flash_applied = 1'b1;
				end
			end
			default: ; // spare code: plain read of the slot, no flags
		endcase
		r.credits_left = bkt_credits[s];
		r.warn_count   = bkt_warns[s];
		r.flash_left   = bkt_flash[s];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard state
	// ------------------------------------------------------------------
	item_t   access_queue[$];    // beats waiting for the driver
	result_t bucket_results_due[$];
	int      beats_queued   = 0;
	int      beats_accepted = 0;
	int      results_seen   = 0;
	int      fail_count     = 0;

	task automatic report_mismatch(string what);
		fail_count++;
		if (fail_count <= 50)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s got %0d want %0d",
				results_seen, name, got, want));
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of random length separated by random gaps. A beat that
	// is stalled is held unchanged; a new one is loaded only after accept.
	// ------------------------------------------------------------------
	item_t next_beat;
	int    burst_left = 4;
	int    gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left != 0 || access_queue.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left != 0)
					gap_left--;
			end else begin
				next_beat   = access_queue.pop_front();
				in_valid    <= 1'b1;
				action      <= next_beat.action;
				slot        <= next_beat.slot;
				now_seconds <= NOW_W'(next_beat.now);
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 16);
					// a quarter of bursts run straight into the next one
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall pattern steps through never, light, heavy and alternating,
	// plus one long hold-off that lets the block back up and push stall onto
	// its input.
	// ------------------------------------------------------------------
	int unsigned rx_cycle  = 0;
	int          hold_left = 0;
	bit          held_off  = 1'b0;
	bit          stall_next;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			rx_cycle++;
			if (!held_off && results_seen >= HOLD_AT) begin
				held_off  = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else begin
				case ((rx_cycle / 97) % 4)
					0: stall_next = 1'b0;
					1: stall_next = ($urandom_range(0, 3) == 0);
					2: stall_next = ($urandom_range(0, 3) != 0);
					default: stall_next = rx_cycle[0];
				endcase
			end
			out_stall <= stall_next;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: values sampled at the edge are the pre-edge ones, so accept
	// conditions here match what the block sees.
	// ------------------------------------------------------------------
	result_t want;
	item_t   seen_beat;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (bucket_results_due.size() == 0) begin
					report_mismatch("result beat with no prediction outstanding");
				end else begin
					want = bucket_results_due.pop_front();
					check_field("credits_left", credits_left, want.credits_left);
					check_field("exhausted", exhausted, want.exhausted);
					check_field("repeat_exhaust", repeat_exhaust, want.repeat_exhaust);
					check_field("low_warning", low_warning, want.low_warning);
					check_field("warn_count", warn_count, want.warn_count);
					check_field("flash_left", flash_left, want.flash_left);
					check_field("flash_applied", flash_applied, want.flash_applied);
					check_field("not_ready", not_ready, want.not_ready);
				end
				results_seen++;
			end
			if (in_valid && !in_stall) begin
				seen_beat.action = action;
				seen_beat.slot   = slot;
				seen_beat.now    = now_seconds[TW-1:0];
				bucket_results_due.push_back(bucket_step(seen_beat));
				beats_accepted++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	logic [31:0] sim_now = 32'd1000;

	task automatic queue_beat(logic [ACT_W-1:0] act, int unsigned idx, logic [31:0] t);
		item_t b;
		b.action = act;
		b.slot   = SLOT_W'(idx);
		b.now    = TW'(t);
		access_queue.push_back(b);
		beats_queued++;
	endtask

	// mostly small forward steps; some long gaps, some earlier or equal
	// times, and a few fully random stamps so every time bit toggles
	function automatic logic [31:0] next_time();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			sim_now = sim_now + $urandom_range(0, 40);
		else if (r < 75)
			sim_now = sim_now + $urandom_range(1024, 5000);
		else if (r < 85)
			sim_now = sim_now - $urandom_range(1, 100);
		else if (r < 95)
			sim_now = sim_now;
		else
			sim_now = $urandom();
		return sim_now;
	endfunction

	task automatic queue_random_beat(int unsigned slot_hi);
		int unsigned r;
		int unsigned idx;
		r   = $urandom_range(0, 99);
		idx = $urandom_range(0, slot_hi);
		if (r < 30)
			queue_beat(ACT_REFILL, idx, next_time());
		else if (r < 80)
			queue_beat(ACT_CHARGE, idx, $urandom());
		else if (r < 97)
			queue_beat(ACT_FLASH, idx, $urandom());
		else
			queue_beat(ACT_SPARE, idx, $urandom());
	endtask

	// register writes on consecutive edges; shadow follows right away since
	// nothing is in flight
	task automatic write_reg(logic [CFG_IW-1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DW'(val);
		case (idx)
			REG_MAX_CREDITS:     cfg_max    = CRED_W'(val);
			REG_REFILL_RATE:     cfg_rate   = CRED_W'(val);
			REG_CHARGE_AMOUNT:   cfg_charge = CRED_W'(val);
			REG_FLASH_AMOUNT:    cfg_flash  = CRED_W'(val);
			REG_FLASH_ALLOWANCE: cfg_allow  = FLASH_W'(val);
			REG_WARN_LEVEL:      cfg_warn   = CRED_W'(val);
			default: ;
		endcase
	endtask

	task automatic set_config(int unsigned mx, int unsigned rate, int unsigned chg,
			int unsigned fl, int unsigned allow, int unsigned warn);
		write_reg(REG_MAX_CREDITS, mx);
		write_reg(REG_REFILL_RATE, rate);
		write_reg(REG_CHARGE_AMOUNT, chg);
		write_reg(REG_FLASH_AMOUNT, fl);
		write_reg(REG_FLASH_ALLOWANCE, allow);
		write_reg(REG_WARN_LEVEL, warn);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for every queued beat to be accepted and answered, then let the
	// pipeline settle before anything touches the registers
	task automatic drain();
		int waited;
		waited = 0;
		while ((beats_accepted != beats_queued || bucket_results_due.size() != 0)
				&& waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (beats_accepted != beats_queued || bucket_results_due.size() != 0)
			report_mismatch($sformatf("%0d beats unaccepted, %0d results never arrived",
				beats_queued - beats_accepted, bucket_results_due.size()));
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			bkt_credits[i] = '0;
			bkt_last[i]    = '0;
			bkt_warns[i]   = '0;
			bkt_flash[i]   = '0;
			bkt_live[i]    = 1'b0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset config. Untouched slot first, then init, flash until the
		// allowance runs out, earlier and wrapped times, and a spare code read.
		queue_beat(ACT_CHARGE, 0, 32'd0);
		queue_beat(ACT_FLASH, 0, 32'd0);
		queue_beat(ACT_SPARE, 0, 32'd0);
		queue_beat(ACT_REFILL, 0, 32'd100);
		queue_beat(ACT_FLASH, 0, 32'd0);
		queue_beat(ACT_FLASH, 0, 32'd0);
		queue_beat(ACT_FLASH, 0, 32'd0);
		queue_beat(ACT_REFILL, 0, 32'd50);
		queue_beat(ACT_REFILL, 0, 32'd60);
		queue_beat(ACT_CHARGE, 0, 32'hFFFF_FFFF);
		queue_beat(ACT_REFILL, 0, 32'hFFFF_FFFF);
		queue_beat(ACT_REFILL, 0, 32'd0);
		queue_beat(ACT_SPARE, 0, 32'd0);
		queue_beat(ACT_CHARGE, 15, 32'd0);
		drain();

		// Big charges walk slot 1 through warnings into a repeat exhaustion;
		// full-size flash floors at zero; slot 2 is charged before its init.
		set_config(1023, 1023, 250, 1023, 3, 400);
		queue_beat(ACT_REFILL, 1, 32'd10);
		repeat (5) queue_beat(ACT_CHARGE, 1, 32'd0);
		queue_beat(ACT_REFILL, 1, 32'd11);
		queue_beat(ACT_FLASH, 1, 32'd0);
		queue_beat(ACT_CHARGE, 1, 32'd0);
		queue_beat(ACT_CHARGE, 2, 32'd0);
		queue_beat(ACT_REFILL, 2, 32'd5);
		drain();

		// Zero charge with top warn level: every charge warns, so hammering
		// one slot drives its warning count into saturation. The long
		// receiver hold-off lands in this phase.
		set_config(1023, 5, 0, 1, 1, 1023);
		queue_beat(ACT_REFILL, 0, next_time());
		for (int i = 0; i < 280; i++) begin
			int unsigned r;
			r = $urandom_range(0, 99);
			if (r < 95)
				queue_beat(ACT_CHARGE, 0, $urandom());
			else if (r < 98)
				queue_beat(ACT_REFILL, 0, next_time());
			else
				queue_random_beat(5);
		end
		drain();

		// low extremes, zero capacity included
		set_config(0, 0, 0, 0, 0, 0);
		repeat (45) queue_random_beat(7);
		drain();

		// capacity of one against maximum rate and amounts
		set_config(1, 1023, 1023, 1023, 3, 1023);
		repeat (45) queue_random_beat(9);
		drain();

		// random settings, widening the slot range so new slots get
		// initialized under each one; allowance data carries upper bits too
		for (int p = 0; p < 3; p++) begin
			set_config($urandom_range(1, 1023),
				$urandom_range(0, 1023) >> $urandom_range(0, 9),
				$urandom_range(0, 1023) >> $urandom_range(0, 6),
				$urandom_range(0, 1023) >> $urandom_range(0, 6),
				$urandom_range(0, 1023),
				$urandom_range(0, 1023) >> $urandom_range(0, 3));
			repeat (40) queue_random_beat(11 + 2 * p);
			drain();
		end

		// back to the reset values across all slots
		set_config(600, 1, 40, 20, 2, 40);
		repeat (50) queue_random_beat(SLOTS - 1);
		drain();

		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#10000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
